@@ design/mwss_pkg.sv @@
package mwss_pkg;

   localparam int TableDepth = 256;
   localparam int IdxWidth = $clog2(TableDepth);
   localparam int CntWidth = $clog2(TableDepth + 1);
   localparam int SymWidth = 21;
   localparam int WgtWidth = 16;
   localparam int RndWidth = 32;
   localparam int SumWidth = 32;
   localparam int LenWidth = 8;
   localparam int KeyWidth = 2 * SymWidth;
   localparam int DivCntWidth = $clog2(RndWidth + 1);

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_SAMPLE = 2'd2;

   localparam logic [LenWidth-1:0] MaxLengthReset = LenWidth'(32);

   // controller to datapath commands
   typedef struct packed {
      logic capture;     // latch the request and start a step
      logic load_entry;  // write the latched entry
      logic clear_table; // drop all entries
      logic sum_clear;   // reset the sum and scan index
      logic sum_step;    // accumulate one entry
      logic div_start;   // start the modulo reduction
      logic div_step;    // one restoring division step
      logic pick_clear;  // reset scan index for the pick pass
      logic pick_step;   // test one entry
      logic finish_miss; // post a not-found sample result
      logic finish_hit;  // post a sample result and advance or reset the context
      logic finish_misc; // post a load, clear or unused result
   } mwss_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [1:0] cmd;
      logic       table_full;
      logic       scan_done;
      logic       sum_zero;
      logic       div_done;
      logic       found;
   } mwss_stat_type;

endpackage

@@ design/mwss_datapath.sv @@
module mwss_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  mwss_pkg::mwss_cmd_type      ctl,
   output mwss_pkg::mwss_stat_type     stat,
   input  logic [1:0]                  req_cmd,
   input  logic [mwss_pkg::SymWidth-1:0] req_ctx_first,
   input  logic [mwss_pkg::SymWidth-1:0] req_ctx_second,
   input  logic [mwss_pkg::SymWidth-1:0] req_next_symbol,
   input  logic [mwss_pkg::WgtWidth-1:0] req_weight,
   input  logic [mwss_pkg::RndWidth-1:0] req_random_word,
   input  logic [mwss_pkg::LenWidth-1:0] max_length,
   output logic [mwss_pkg::SymWidth-1:0] res_symbol,
   output logic                        res_word_end,
   output logic                        res_not_found,
   output logic [mwss_pkg::LenWidth-1:0] res_count
);
   import mwss_pkg::*;

   logic [KeyWidth-1:0] key_mem [TableDepth];
   logic [SymWidth+WgtWidth-1:0] sw_mem [TableDepth];

   logic [1:0] cmd_ff;
   logic [SymWidth-1:0] first_ff, second_ff, next_ff;
   logic [WgtWidth-1:0] weight_ff;
   logic [RndWidth-1:0] rnd_ff;
   logic [CntWidth-1:0] count_ff;
   logic [SymWidth-1:0] older_ff, newer_ff;
   logic [LenWidth-1:0] pos_ff;
   logic [CntWidth-1:0] scan_ff;
   logic [SumWidth-1:0] sum_ff;
   logic [SumWidth-1:0] rem_ff;
   logic [RndWidth-1:0] quo_ff;
   logic [DivCntWidth-1:0] div_ff;
   logic found_ff;
   logic [SymWidth-1:0] pick_ff;
   logic [KeyWidth-1:0] key_rd_ff;
   logic [SymWidth+WgtWidth-1:0] sw_rd_ff;
   logic rd_valid_ff;

   logic [KeyWidth-1:0] cur_key;
   logic key_hit;
   logic [WgtWidth-1:0] rd_weight;
   logic [SumWidth:0] rem_shift;
   logic [LenWidth-1:0] pos_in;
   logic [IdxWidth-1:0] rd_addr;

   assign cur_key = {older_ff, newer_ff};
   assign key_hit = (key_rd_ff == cur_key);
   assign rd_weight = sw_rd_ff[WgtWidth-1:0];
   assign rem_shift = {rem_ff, quo_ff[RndWidth-1]};
   assign pos_in = pos_ff + LenWidth'(1);
   assign rd_addr = scan_ff[IdxWidth-1:0];

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctl.load_entry) begin
         key_mem[count_ff[IdxWidth-1:0]] <= {first_ff, second_ff};
         sw_mem[count_ff[IdxWidth-1:0]] <= {next_ff, weight_ff};
      end
      key_rd_ff <= key_mem[rd_addr];
      sw_rd_ff <= sw_mem[rd_addr];
   end

   // latch request payload
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff <= req_cmd;
         first_ff <= req_ctx_first;
         second_ff <= req_ctx_second;
         next_ff <= req_next_symbol;
         weight_ff <= req_weight;
         rnd_ff <= req_random_word;
      end
   end

   // scan passes: read issued one cycle, compared the next
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (ctl.sum_clear || ctl.pick_clear) begin
         rd_valid_ff <= 1'b0;
      end else if (ctl.sum_step || ctl.pick_step) begin
         rd_valid_ff <= (scan_ff < count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.sum_clear || ctl.pick_clear) begin
         scan_ff <= '0;
      end else if ((ctl.sum_step || ctl.pick_step) && scan_ff < count_ff) begin
         scan_ff <= scan_ff + CntWidth'(1);
      end
      if (ctl.sum_clear) begin
         sum_ff <= '0;
      end else if (ctl.sum_step && rd_valid_ff && key_hit) begin
         sum_ff <= sum_ff + SumWidth'(rd_weight);
      end
      // restoring division of random word by sum; remainder in rem_ff
      if (ctl.div_start) begin
         rem_ff <= '0;
         quo_ff <= rnd_ff;
         div_ff <= '0;
      end else if (ctl.div_step) begin
         quo_ff <= {quo_ff[RndWidth-2:0], 1'b0};
         div_ff <= div_ff + DivCntWidth'(1);
         if (rem_shift >= {1'b0, sum_ff}) begin
            rem_ff <= SumWidth'(rem_shift - {1'b0, sum_ff});
         end else begin
            rem_ff <= rem_shift[SumWidth-1:0];
         end
      end else if (ctl.pick_step && rd_valid_ff && key_hit && !found_ff) begin
         if (rem_ff >= SumWidth'(rd_weight)) begin
            rem_ff <= rem_ff - SumWidth'(rd_weight);
         end
      end
      if (ctl.pick_clear) begin
         found_ff <= 1'b0;
         pick_ff <= '0;
      end else if (ctl.pick_step && rd_valid_ff && key_hit && !found_ff &&
                   rem_ff < SumWidth'(rd_weight)) begin
         found_ff <= 1'b1;
         pick_ff <= sw_rd_ff[SymWidth+WgtWidth-1:WgtWidth];
      end
   end

   // table fill, context and word position
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         older_ff <= '0;
         newer_ff <= '0;
         pos_ff <= '0;
      end else begin
         if (ctl.load_entry) begin
            count_ff <= count_ff + CntWidth'(1);
         end
         if (ctl.clear_table) begin
            count_ff <= '0;
         end
         if (ctl.finish_miss) begin
            older_ff <= '0;
            newer_ff <= '0;
            pos_ff <= '0;
         end
         if (ctl.finish_hit) begin
            if (pick_ff == '0 || pos_in >= max_length) begin
               older_ff <= '0;
               newer_ff <= '0;
               pos_ff <= '0;
            end else begin
               older_ff <= newer_ff;
               newer_ff <= pick_ff;
               pos_ff <= pos_in;
            end
         end
      end
   end

   // result fields
   always_comb begin
      res_symbol = '0;
      res_word_end = 1'b0;
      res_not_found = 1'b0;
      res_count = pos_ff;
      if (ctl.finish_miss) begin
         res_word_end = 1'b1;
         res_not_found = 1'b1;
      end else if (ctl.finish_hit) begin
         res_symbol = pick_ff;
         res_word_end = (pick_ff == '0) || (pos_in >= max_length);
         res_count = pos_in;
      end else if (ctl.finish_misc) begin
         res_not_found = (cmd_ff == CMD_LOAD) && (count_ff >= CntWidth'(TableDepth));
      end
   end

   assign stat.cmd = cmd_ff;
   assign stat.table_full = (count_ff >= CntWidth'(TableDepth));
   assign stat.scan_done = !rd_valid_ff && (scan_ff >= count_ff);
   assign stat.sum_zero = (sum_ff == '0);
   assign stat.div_done = (div_ff == DivCntWidth'(RndWidth));
   assign stat.found = found_ff;

endmodule

@@ design/mwss_control.sv @@
module mwss_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    post,
   input  logic                    slot_free,
   input  mwss_pkg::mwss_stat_type stat,
   output mwss_pkg::mwss_cmd_type  ctl
);
   import mwss_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SUM = 3'd2;
   localparam logic [2:0] S_DIV = 3'd3;
   localparam logic [2:0] S_PICK = 3'd4;
   localparam logic [2:0] S_POST = 3'd5;

   logic [2:0] state_ff, state_in;
   logic miss_ff, miss_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      miss_in = miss_ff;
      ctl = '0;
      post = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.cmd == CMD_SAMPLE) begin
               ctl.sum_clear = 1'b1;
               state_in = S_SUM;
            end else begin
               state_in = S_POST;
            end
         end
         S_SUM: begin
            ctl.sum_step = 1'b1;
            if (stat.scan_done) begin
               ctl.sum_step = 1'b0;
               miss_in = stat.sum_zero;
               ctl.div_start = 1'b1;
               state_in = stat.sum_zero ? S_POST : S_DIV;
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               ctl.pick_clear = 1'b1;
               state_in = S_PICK;
            end else begin
               ctl.div_step = 1'b1;
            end
         end
         S_PICK: begin
            ctl.pick_step = 1'b1;
            if (stat.scan_done || stat.found) begin
               ctl.pick_step = 1'b0;
               state_in = S_POST;
            end
         end
         S_POST: begin
            if (slot_free) begin
               post = 1'b1;
               state_in = S_IDLE;
               if (stat.cmd != CMD_SAMPLE) begin
                  ctl.finish_misc = 1'b1;
                  ctl.load_entry = (stat.cmd == CMD_LOAD) && !stat.table_full;
                  ctl.clear_table = (stat.cmd == CMD_CLEAR);
               end else if (miss_ff) begin
                  ctl.finish_miss = 1'b1;
               end else begin
                  ctl.finish_hit = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         miss_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         miss_ff <= miss_in;
      end
   end

endmodule

@@ design/markov2_weighted_symbol_sampler.sv @@
// A load, clear or unused command passes through the decode and post states
// before its result beat is registered. A sample scans the table (sum) through
// its single read port, then, for a nonzero sum, runs 32 division steps and
// scans again (pick). One request at a time; a new request is taken once the
// result is registered. Synchronous active-high reset empties the table, clears
// context and count, and sets max_length to 32.
module markov2_weighted_symbol_sampler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mwss_pkg::LenWidth-1:0] csr_max_length,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_cmd,
   input  logic [mwss_pkg::SymWidth-1:0] req_ctx_first,
   input  logic [mwss_pkg::SymWidth-1:0] req_ctx_second,
   input  logic [mwss_pkg::SymWidth-1:0] req_next_symbol,
   input  logic [mwss_pkg::WgtWidth-1:0] req_weight,
   input  logic [mwss_pkg::RndWidth-1:0] req_random_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mwss_pkg::SymWidth-1:0] rsp_symbol_out,
   output logic                          rsp_word_end,
   output logic                          rsp_not_found,
   output logic [mwss_pkg::LenWidth-1:0] rsp_symbol_count
);
   import mwss_pkg::*;

   mwss_cmd_type ctl;
   mwss_stat_type stat;
   logic post;
   logic [LenWidth-1:0] max_len_ff;
   logic [SymWidth-1:0] res_symbol;
   logic res_word_end, res_not_found;
   logic [LenWidth-1:0] res_count;
   logic valid_ff;

   assign csr_ready = 1'b1;

   // hold the length limit
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MaxLengthReset;
      end else if (csr_valid) begin
         max_len_ff <= csr_max_length;
      end
   end

   mwss_control u_control (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .post(post), .slot_free(!valid_ff || rsp_ready), .stat(stat), .ctl(ctl)
   );

   mwss_datapath u_datapath (
      .clock(clock), .reset(reset), .ctl(ctl), .stat(stat),
      .req_cmd(req_cmd), .req_ctx_first(req_ctx_first),
      .req_ctx_second(req_ctx_second), .req_next_symbol(req_next_symbol),
      .req_weight(req_weight), .req_random_word(req_random_word),
      .max_length(max_len_ff), .res_symbol(res_symbol),
      .res_word_end(res_word_end), .res_not_found(res_not_found),
      .res_count(res_count)
   );

   // result register: hold the beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (post) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (post) begin
         rsp_symbol_out <= res_symbol;
         rsp_word_end <= res_word_end;
         rsp_not_found <= res_not_found;
         rsp_symbol_count <= res_count;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

@@ design/mwss_checker.sv @@
module mwss_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mwss_pkg::SymWidth-1:0] rsp_symbol_out,
   input logic                          rsp_word_end,
   input logic                          rsp_not_found
);
   import mwss_pkg::*;

   // a pending beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped");

   // a taken request drops req_ready while the controller works on it
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // not found carries no symbol
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_not_found |-> rsp_symbol_out == '0)
      else $error("symbol on not-found");

   // a waiting beat keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_symbol_out) && $stable(rsp_word_end) &&
                                  $stable(rsp_not_found))
      else $error("result payload changed while waiting");

endmodule

bind markov2_weighted_symbol_sampler mwss_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_symbol_out(rsp_symbol_out),
   .rsp_word_end(rsp_word_end), .rsp_not_found(rsp_not_found)
);
